@@ design/i2cm_pkg.sv @@
// i2cm_pkg: shared types, opcodes and constants of the i2c master bit engine
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

    localparam int unsigned SLOT_W     = 16;
    localparam int unsigned STEP_W     = 5;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // register map
    localparam logic REG_SLOT_CYCLES = 1'b0;

    localparam logic [SLOT_W-1:0] SLOT_CYCLES_RESET = SLOT_W'(1000);

    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_SACK  = 3'd4,
        OP_RACK  = 3'd5
    } opcode_t;

    // one command word as seen by the sequencer
    typedef struct packed {
        logic              cmd_valid;
        logic [2:0]        opcode;
        logic [BYTE_W-1:0] tx_byte;
        logic              ack_level;
        logic              sda_in;
    } cmd_t;

    // one result word
    typedef struct packed {
        logic              scl_out;
        logic              sda_out;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              rx_ack;
    } res_t;

    // number of slots in each command sequence
    function automatic logic [STEP_W-1:0] step_count(input opcode_t op);
        logic [STEP_W-1:0] cnt;
        unique case (op)
            OP_START: cnt = STEP_W'(4);
            OP_STOP:  cnt = STEP_W'(3);
            OP_WRITE: cnt = STEP_W'(24);
            OP_READ:  cnt = STEP_W'(25);
            OP_SACK:  cnt = STEP_W'(3);
            default:  cnt = STEP_W'(4);
        endcase
        return cnt;
    endfunction

endpackage

`default_nettype wire

@@ design/i2cm_cmd_if.sv @@
// i2cm_cmd_if: valid/ready channel carrying one command word per tick
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface i2cm_cmd_if;
    logic       valid;
    logic       ready;
    logic       cmd_valid;
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic       sda_in;

    modport source (
        output valid, cmd_valid, opcode, tx_byte, ack_level, sda_in,
        input  ready
    );

    modport sink (
        input  valid, cmd_valid, opcode, tx_byte, ack_level, sda_in,
        output ready
    );
endinterface

`default_nettype wire

@@ design/i2cm_res_if.sv @@
// i2cm_res_if: valid/ready channel carrying one result word per tick
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface i2cm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       rx_ack;

    modport source (
        output valid, scl_out, sda_out, busy_res, done_res, rx_byte, rx_ack,
        input  ready
    );

    modport sink (
        input  valid, scl_out, sda_out, busy_res, done_res, rx_byte, rx_ack,
        output ready
    );
endinterface

`default_nettype wire

@@ design/i2cm_apb_regs.sv @@
// i2cm_apb_regs: apb register block holding the slot length
// depends on i2cm_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2cm_apb_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [i2cm_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [i2cm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [i2cm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output logic      [i2cm_pkg::SLOT_W-1:0]      slot_cycles
);
    import i2cm_pkg::*;

    logic [SLOT_W-1:0] slot_cycles_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_W-1] == REG_SLOT_CYCLES);

    // slot length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_cycles_reg <= SLOT_CYCLES_RESET;
        end
        else if (wr_en)
        begin
            slot_cycles_reg <= pwdata[SLOT_W-1:0];
        end
    end

    // read mux
    always_comb
    begin
        if (paddr[APB_ADDR_W-1] == REG_SLOT_CYCLES)
        begin
            prdata = APB_DATA_W'(slot_cycles_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    assign slot_cycles = slot_cycles_reg;

endmodule

`default_nettype wire

@@ design/i2cm_seq.sv @@
// i2cm_seq: slot sequencer state and its single-pass next-state logic
// depends on i2cm_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2cm_seq (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire i2cm_pkg::cmd_t               cmd,
    input  wire logic [i2cm_pkg::SLOT_W-1:0]  slot_cycles,
    output i2cm_pkg::res_t                    res_next
);
    import i2cm_pkg::*;

    logic [SLOT_W-1:0] timer_reg, timer_next;
    logic [STEP_W-1:0] step_reg, step_next;
    opcode_t           op_reg, op_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic              ack_reg, ack_next;
    logic              busy_reg, busy_next;
    logic [BYTE_W-1:0] rx_reg, rx_next;

    logic              start;
    opcode_t           op_a;
    logic [BYTE_W-1:0] shift_a;
    logic [STEP_W-1:0] step_a;
    logic [STEP_W-1:0] step_inc;
    logic [STEP_W-1:0] pos;
    logic [SLOT_W-1:0] timer_b;
    logic [4:0]        pos_split;
    logic [2:0]        bit_k;
    logic [1:0]        phase;
    logic              done;

    // split a slot position into bit number and phase within the bit
    function automatic logic [4:0] div3(input logic [STEP_W-1:0] s);
        logic [2:0]        k;
        logic [STEP_W-1:0] rem;
        k = '0;
        for (int i = 1; i < 8; i++)
        begin
            if (s >= STEP_W'(3 * i))
            begin
                k = 3'(i);
            end
        end
        rem = s - (STEP_W'(k) * STEP_W'(3));
        return {k, rem[1:0]};
    endfunction

    // command capture, slot action and slot timing
    always_comb
    begin
        start = !busy_reg && cmd.cmd_valid && (cmd.opcode <= 3'(OP_RACK));
        op_a  = start ? opcode_t'(cmd.opcode) : op_reg;

        shift_a = shift_reg;
        if (start)
        begin
            if (cmd.opcode == 3'(OP_WRITE))
            begin
                shift_a = cmd.tx_byte;
            end
            else if (cmd.opcode == 3'(OP_READ))
            begin
                shift_a = '0;
            end
            else if (cmd.opcode == 3'(OP_SACK))
            begin
                shift_a = BYTE_W'(cmd.ack_level);
            end
        end

        step_a    = start ? '0 : step_reg;
        timer_b   = start ? '0 : timer_reg;
        busy_next = busy_reg || start;

        pos       = (op_a == OP_READ) ? (step_a - STEP_W'(1)) : step_a;
        pos_split = div3(pos);
        bit_k     = pos_split[4:2];
        phase     = pos_split[1:0];

        op_next    = op_a;
        shift_next = shift_a;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        rx_next    = rx_reg;
        step_next  = step_a;
        timer_next = timer_b;
        step_inc   = step_a + STEP_W'(1);
        done       = 1'b0;

        if (busy_next)
        begin
            // first tick of a slot: perform its pin change or sample
            if (timer_b == '0)
            begin
                unique case (op_a)
                    OP_START:
                    begin
                        if (step_a == STEP_W'(0))      sda_next = 1'b1;
                        else if (step_a == STEP_W'(1)) scl_next = 1'b1;
                        else if (step_a == STEP_W'(2)) sda_next = 1'b0;
                        else                           scl_next = 1'b0;
                    end
                    OP_STOP:
                    begin
                        if (step_a == STEP_W'(0))      sda_next = 1'b0;
                        else if (step_a == STEP_W'(1)) scl_next = 1'b1;
                        else                           sda_next = 1'b1;
                    end
                    OP_WRITE:
                    begin
                        if (phase == 2'd0)      sda_next = shift_a[~bit_k];
                        else if (phase == 2'd1) scl_next = 1'b1;
                        else                    scl_next = 1'b0;
                    end
                    OP_READ:
                    begin
                        if (step_a == STEP_W'(0))  sda_next = 1'b1;
                        else if (phase == 2'd0)    scl_next = 1'b1;
                        else if (phase == 2'd1)    shift_next = {shift_a[BYTE_W-2:0], cmd.sda_in};
                        else                       scl_next = 1'b0;
                    end
                    OP_SACK:
                    begin
                        if (step_a == STEP_W'(0))      sda_next = shift_a[0];
                        else if (step_a == STEP_W'(1)) scl_next = 1'b1;
                        else                           scl_next = 1'b0;
                    end
                    default:
                    begin
                        // receive ack
                        if (step_a == STEP_W'(0))      sda_next = 1'b1;
                        else if (step_a == STEP_W'(1)) scl_next = 1'b1;
                        else if (step_a == STEP_W'(2)) ack_next = cmd.sda_in;
                        else                           scl_next = 1'b0;
                    end
                endcase
                timer_b = (slot_cycles == '0) ? SLOT_W'(1) : slot_cycles;
            end

            // count down the slot, advance step at its end
            timer_next = timer_b - SLOT_W'(1);
            if (timer_next == '0)
            begin
                if (step_inc >= step_count(op_a))
                begin
                    if (op_a == OP_READ)
                    begin
                        rx_next = shift_next;
                    end
                    busy_next = 1'b0;
                    step_next = '0;
                    done      = 1'b1;
                end
                else
                begin
                    step_next = step_inc;
                end
            end
        end

        res_next.scl_out  = scl_next;
        res_next.sda_out  = sda_next;
        res_next.busy_res = busy_reg || start;
        res_next.done_res = done;
        res_next.rx_byte  = rx_next;
        res_next.rx_ack   = ack_next;
    end

    // sequencer state, updated once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg <= '0;
            step_reg  <= '0;
            op_reg    <= OP_START;
            shift_reg <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            ack_reg   <= 1'b1;
            busy_reg  <= 1'b0;
            rx_reg    <= '0;
        end
        else if (accept)
        begin
            timer_reg <= timer_next;
            step_reg  <= step_next;
            op_reg    <= op_next;
            shift_reg <= shift_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ack_reg   <= ack_next;
            busy_reg  <= busy_next;
            rx_reg    <= rx_next;
        end
    end

endmodule

`default_nettype wire

@@ design/i2c_master_bit_engine_top.sv @@
// i2c_master_bit_engine_top: top level of the i2c master bit engine
// depends on i2cm_pkg, i2cm_cmd_if, i2cm_res_if, i2cm_apb_regs, i2cm_seq
`timescale 1ns / 1ps
`default_nettype none

// Each input word is one tick of the I2C line sequencer and yields exactly one
// result word through a result register; a new word is taken
// every cycle unless that register holds a word the sink has not taken. A
// command (start, stop, write, read, send ack, receive ack) is honored only
// while the engine is idle and then runs 3 to 25 slots of slot_cycles ticks
// each (slot_cycles of zero counts as one). slot_cycles sits at APB offset 0,
// resets to 1000 and should be written only while the engine is idle.

module i2c_master_bit_engine_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [i2cm_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [i2cm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [i2cm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    i2cm_cmd_if.sink                              cmd,
    i2cm_res_if.source                            res
);
    import i2cm_pkg::*;

    logic [SLOT_W-1:0] slot_cycles;
    cmd_t              cmd_word;
    res_t              res_next;
    res_t              res_reg;
    logic              out_valid_reg;
    logic              accept;

    i2cm_apb_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .slot_cycles (slot_cycles)
    );

    // pack the incoming word
    always_comb
    begin
        cmd_word.cmd_valid = cmd.cmd_valid;
        cmd_word.opcode    = cmd.opcode;
        cmd_word.tx_byte   = cmd.tx_byte;
        cmd_word.ack_level = cmd.ack_level;
        cmd_word.sda_in    = cmd.sda_in;
    end

    // take a word whenever the result register is free or being drained
    assign cmd.ready = !out_valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;

    i2cm_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .cmd         (cmd_word),
        .slot_cycles (slot_cycles),
        .res_next    (res_next)
    );

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid    = out_valid_reg;
    assign res.scl_out  = res_reg.scl_out;
    assign res.sda_out  = res_reg.sda_out;
    assign res.busy_res = res_reg.busy_res;
    assign res.done_res = res_reg.done_res;
    assign res.rx_byte  = res_reg.rx_byte;
    assign res.rx_ack   = res_reg.rx_ack;

endmodule

`default_nettype wire
